// ----- design/eatrm_pkg.sv -----
package eatrm_pkg;

  localparam int AngleW    = 16;
  localparam int AngleFrac = 13;
  localparam int OutW      = 16;
  localparam int OutFrac   = 14;
  localparam int WorkFrac  = 30;
  localparam int Steps     = 32;
  localparam int ZW        = 40;
  localparam int XW        = 36;
  localparam int PW        = 34;
  localparam int PhaseW    = 6;

  localparam logic signed [ZW-1:0] HalfPiQ32 = 40'sd6746518852;
  localparam logic signed [XW-1:0] KinvQ30   = 36'sd652032874;

  typedef logic signed [AngleW-1:0] angle_t;
  typedef logic signed [OutW-1:0]   out_t;
  typedef logic signed [PW-1:0]     prod_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           quad;
  } rot_t;

  // arctangent of 2^-i with 32 fractional bits
  function automatic logic signed [ZW-1:0] atan_q32(input logic [PhaseW-1:0] i);
    logic signed [ZW-1:0] r;
    begin
      unique case (i)
        6'd0:  r = 40'sd3373259426;
        6'd1:  r = 40'sd1991351318;
        6'd2:  r = 40'sd1052175346;
        6'd3:  r = 40'sd534100635;
        6'd4:  r = 40'sd268086748;
        6'd5:  r = 40'sd134174063;
        6'd6:  r = 40'sd67103403;
        6'd7:  r = 40'sd33553749;
        6'd8:  r = 40'sd16777131;
        6'd9:  r = 40'sd8388597;
        6'd10: r = 40'sd4194303;
        6'd11: r = 40'sd2097152;
        6'd12: r = 40'sd1048576;
        6'd13: r = 40'sd524288;
        6'd14: r = 40'sd262144;
        6'd15: r = 40'sd131072;
        6'd16: r = 40'sd65536;
        6'd17: r = 40'sd32768;
        6'd18: r = 40'sd16384;
        6'd19: r = 40'sd8192;
        6'd20: r = 40'sd4096;
        6'd21: r = 40'sd2048;
        6'd22: r = 40'sd1024;
        6'd23: r = 40'sd512;
        6'd24: r = 40'sd256;
        6'd25: r = 40'sd128;
        6'd26: r = 40'sd64;
        6'd27: r = 40'sd32;
        6'd28: r = 40'sd16;
        6'd29: r = 40'sd8;
        6'd30: r = 40'sd4;
        6'd31: r = 40'sd2;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // round to nearest, ties up, dropping WorkFrac bits
  function automatic prod_t qmul(input prod_t a, input prod_t b);
    logic signed [2*PW-1:0] p;
    begin
      p = a * b + (68'sd1 <<< (WorkFrac - 1));
      return p[WorkFrac +: PW];
    end
  endfunction

  function automatic out_t to_out(input logic signed [PW+1:0] v);
    logic signed [PW+1:0] o;
    begin
      o = (v + (36'sd1 <<< (WorkFrac - OutFrac - 1))) >>> (WorkFrac - OutFrac);
      if (o > (36'sd1 <<< OutFrac)) o = 36'sd1 <<< OutFrac;
      if (o < -(36'sd1 <<< OutFrac)) o = -(36'sd1 <<< OutFrac);
      return o[OutW-1:0];
    end
  endfunction

endpackage

// ----- design/eatrm_cell.sv -----
module eatrm_cell (
  input  logic                     clk,
  input  logic                     en,
  input  logic [eatrm_pkg::PhaseW-1:0] step,
  input  eatrm_pkg::rot_t          d,
  output eatrm_pkg::rot_t          q_r
);
  eatrm_pkg::rot_t q_nxt;
  logic signed [eatrm_pkg::XW-1:0] dx, dy;
  logic signed [eatrm_pkg::ZW-1:0] at;

  always_comb begin
    dx = d.y >>> step;
    dy = d.x >>> step;
    at = eatrm_pkg::atan_q32(step);
    q_nxt = d;
    if (!d.z[eatrm_pkg::ZW-1]) begin
      q_nxt.x = d.x - dx; q_nxt.y = d.y + dy; q_nxt.z = d.z - at;
    end else begin
      q_nxt.x = d.x + dx; q_nxt.y = d.y - dy; q_nxt.z = d.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end
endmodule

// ----- design/eatrm_sincos.sv -----
module eatrm_sincos (
  input  logic                  clk,
  input  logic                  en,
  input  eatrm_pkg::angle_t     ang,
  output eatrm_pkg::prod_t      cos_r,
  output eatrm_pkg::prod_t      sin_r
);
  localparam int N = eatrm_pkg::Steps;

  logic signed [eatrm_pkg::ZW-1:0] a_r, a_nxt;
  logic signed [2:0] k_r, k_nxt;
  logic signed [eatrm_pkg::ZW-1:0] ab;
  logic signed [eatrm_pkg::ZW-1:0] km;
  eatrm_pkg::rot_t seed_r, seed_nxt;
  eatrm_pkg::rot_t chain [N+1];
  eatrm_pkg::prod_t c_nxt, s_nxt;
  logic signed [eatrm_pkg::XW-1:0] fx, fy;

  // stage 0: scale, quadrant count by small compare ladder (|k| <= 3)
  always_comb begin
    a_nxt = eatrm_pkg::ZW'(ang) <<< (32 - eatrm_pkg::AngleFrac);
    ab = a_nxt[eatrm_pkg::ZW-1] ? -a_nxt : a_nxt;
    k_nxt = '0;
    for (int j = 1; j <= 3; j++) begin
      if (ab >= (2*j - 1) * (eatrm_pkg::HalfPiQ32 >>> 1)) k_nxt = 3'(j);
    end
    if (a_nxt[eatrm_pkg::ZW-1]) k_nxt = -k_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
      k_r <= k_nxt;
    end
  end

  // pick the multiple of pi/2 from a few constants
  always_comb begin
    unique case (k_r)
      3'sd0:  km = '0;
      3'sd1:  km = eatrm_pkg::HalfPiQ32;
      3'sd2:  km = eatrm_pkg::HalfPiQ32 <<< 1;
      3'sd3:  km = (eatrm_pkg::HalfPiQ32 <<< 1) + eatrm_pkg::HalfPiQ32;
      -3'sd1: km = -eatrm_pkg::HalfPiQ32;
      -3'sd2: km = -(eatrm_pkg::HalfPiQ32 <<< 1);
      -3'sd3: km = -((eatrm_pkg::HalfPiQ32 <<< 1) + eatrm_pkg::HalfPiQ32);
      default: km = '0;
    endcase
    seed_nxt.x = eatrm_pkg::KinvQ30;
    seed_nxt.y = '0;
    seed_nxt.z = a_r - km;
    seed_nxt.quad = k_r[1:0];
  end

  always_ff @(posedge clk) begin
    if (en) seed_r <= seed_nxt;
  end

  assign chain[0] = seed_r;

  for (genvar i = 0; i < N; i++) begin : g_cell
    eatrm_cell u_cell (
      .clk  (clk),
      .en   (en),
      .step (eatrm_pkg::PhaseW'(i)),
      .d    (chain[i]),
      .q_r  (chain[i+1])
    );
  end

  always_comb begin
    fx = chain[N].x;
    fy = chain[N].y;
    unique case (chain[N].quad)
      2'd0: begin c_nxt = eatrm_pkg::PW'(fx);  s_nxt = eatrm_pkg::PW'(fy);  end
      2'd1: begin c_nxt = eatrm_pkg::PW'(-fy); s_nxt = eatrm_pkg::PW'(fx);  end
      2'd2: begin c_nxt = eatrm_pkg::PW'(-fx); s_nxt = eatrm_pkg::PW'(-fy); end
      default: begin c_nxt = eatrm_pkg::PW'(fy); s_nxt = eatrm_pkg::PW'(-fx); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= c_nxt;
      sin_r <= s_nxt;
    end
  end
endmodule

// ----- design/euler_angles_to_rotation_matrix_unit.sv -----
// Channel  | Handshake            | Payload
// in_      | in_valid / in_ready  | roll, pitch, yaw angles (Q2.13)
// out_     | out_valid / out_ready| nine matrix entries (Q1.14)
//
// One transaction per cycle sustained; the pipeline holds 2 reduction
// stages, 32 CORDIC cells, 1 quadrant fold, 2 product stages and 1 output.
// The whole pipeline advances as one; a stalled output holds every stage,
// and in_ready is high whenever the last stage is empty or being taken.
// Reset clears only the valid bits.
module euler_angles_to_rotation_matrix_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] in_roll_angle,
  input  logic signed [15:0] in_pitch_angle,
  input  logic signed [15:0] in_yaw_angle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_row0_col0,
  output logic signed [15:0] out_row0_col1,
  output logic signed [15:0] out_row0_col2,
  output logic signed [15:0] out_row1_col0,
  output logic signed [15:0] out_row1_col1,
  output logic signed [15:0] out_row1_col2,
  output logic signed [15:0] out_row2_col0,
  output logic signed [15:0] out_row2_col1,
  output logic signed [15:0] out_row2_col2
);
  localparam int Lat = 38;

  logic [Lat-1:0] vld_r, vld_nxt;
  logic en;
  eatrm_pkg::prod_t rc, rs, pc, ps, yc, ys;

  // advance all stages unless the output is full and held
  assign en = !vld_r[Lat-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[Lat-1];

  always_comb begin
    vld_nxt = {vld_r[Lat-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= vld_nxt;
  end

  eatrm_sincos u_roll  (.clk(clk), .en(en), .ang(in_roll_angle),  .cos_r(rc), .sin_r(rs));
  eatrm_sincos u_pitch (.clk(clk), .en(en), .ang(in_pitch_angle), .cos_r(pc), .sin_r(ps));
  eatrm_sincos u_yaw   (.clk(clk), .en(en), .ang(in_yaw_angle),   .cos_r(yc), .sin_r(ys));

  // first products, registered
  eatrm_pkg::prod_t p_cy_r, p_sy_r, p_yps_r, p_rcys_r, p_rcyc_r, p_rsys_r;
  eatrm_pkg::prod_t p_psrs_r, p_rcps_r, p_ycrs_r, p_pcrs_r, p_pcrc_r;
  eatrm_pkg::prod_t ps1_r, rs1_r, ys1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_cy_r   <= eatrm_pkg::qmul(pc, yc);
      p_sy_r   <= eatrm_pkg::qmul(pc, ys);
      p_yps_r  <= eatrm_pkg::qmul(yc, ps);
      p_rcys_r <= eatrm_pkg::qmul(rc, ys);
      p_rcyc_r <= eatrm_pkg::qmul(rc, yc);
      p_rsys_r <= eatrm_pkg::qmul(rs, ys);
      p_psrs_r <= eatrm_pkg::qmul(ps, rs);
      p_rcps_r <= eatrm_pkg::qmul(rc, ps);
      p_ycrs_r <= eatrm_pkg::qmul(yc, rs);
      p_pcrs_r <= eatrm_pkg::qmul(pc, rs);
      p_pcrc_r <= eatrm_pkg::qmul(pc, rc);
      ps1_r <= ps; rs1_r <= rs; ys1_r <= ys;
    end
  end

  // second products, registered
  eatrm_pkg::prod_t t01_r, t02_r, t11_r, t12_r;
  eatrm_pkg::prod_t h00_r, h01_r, h02_r, h10_r, h11_r, h12_r, h20_r, h21_r, h22_r;
  always_ff @(posedge clk) begin
    if (en) begin
      t01_r <= eatrm_pkg::qmul(p_yps_r, rs1_r);
      t02_r <= eatrm_pkg::qmul(p_rcyc_r, ps1_r);
      t11_r <= eatrm_pkg::qmul(p_psrs_r, ys1_r);
      t12_r <= eatrm_pkg::qmul(p_rcps_r, ys1_r);
      h00_r <= p_cy_r;   h01_r <= p_rcys_r; h02_r <= p_rsys_r;
      h10_r <= p_sy_r;   h11_r <= p_rcyc_r; h12_r <= p_ycrs_r;
      h20_r <= -ps1_r;   h21_r <= p_pcrs_r; h22_r <= p_pcrc_r;
    end
  end

  // sum, round and clamp into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_row0_col0 <= eatrm_pkg::to_out(36'(h00_r));
      out_row0_col1 <= eatrm_pkg::to_out(36'(t01_r) - 36'(h01_r));
      out_row0_col2 <= eatrm_pkg::to_out(36'(t02_r) + 36'(h02_r));
      out_row1_col0 <= eatrm_pkg::to_out(36'(h10_r));
      out_row1_col1 <= eatrm_pkg::to_out(36'(h11_r) + 36'(t11_r));
      out_row1_col2 <= eatrm_pkg::to_out(36'(t12_r) - 36'(h12_r));
      out_row2_col0 <= eatrm_pkg::to_out(36'(h20_r));
      out_row2_col1 <= eatrm_pkg::to_out(36'(h21_r));
      out_row2_col2 <= eatrm_pkg::to_out(36'(h22_r));
    end
  end
endmodule

// ----- bench/rotation_matrix_checker.sv -----
module rotation_matrix_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  eatrm_pkg::angle_t in_roll_angle,
  input  eatrm_pkg::angle_t in_pitch_angle,
  input  eatrm_pkg::angle_t in_yaw_angle,
  input  logic              out_valid,
  input  logic              out_ready,
  input  eatrm_pkg::out_t   out_row0_col0,
  input  eatrm_pkg::out_t   out_row0_col1,
  input  eatrm_pkg::out_t   out_row0_col2,
  input  eatrm_pkg::out_t   out_row1_col0,
  input  eatrm_pkg::out_t   out_row1_col1,
  input  eatrm_pkg::out_t   out_row1_col2,
  input  eatrm_pkg::out_t   out_row2_col0,
  input  eatrm_pkg::out_t   out_row2_col1,
  input  eatrm_pkg::out_t   out_row2_col2,
  output int                mismatch_count,
  output int                matrices_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef eatrm_pkg::out_t matrix_t [9];

  localparam int RingDepth = 64;

  longint arctan_q32 [eatrm_pkg::Steps];
  longint quarter_turn_q32;
  matrix_t expected_ring [RingDepth];
  int wr_count, rd_count;

  function automatic longint arctan_inverse_q60(longint unsigned m);
    longint unsigned t, m2, n;
    longint acc, term;
    begin
      t = (64'd1 << 60) / m;
      m2 = m * m;
      n = 0;
      acc = 0;
      while (t != 0) begin
        term = longint'(t / (2 * n + 1));
        acc = n[0] ? acc - term : acc + term;
        t = t / m2;
        n++;
      end
      return acc;
    end
  endfunction

  function automatic longint round_drop(longint v, int s);
    begin
      if (s == 0) return v;
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    end
  endfunction

  function automatic longint round_mul(longint a, longint b);
    return round_drop(a * b, eatrm_pkg::WorkFrac);
  endfunction

  function automatic eatrm_pkg::out_t to_q14(longint v);
    longint o;
    longint lim;
    begin
      o = round_drop(v, eatrm_pkg::WorkFrac - eatrm_pkg::OutFrac);
      lim = 64'sd1 <<< eatrm_pkg::OutFrac;
      if (o > lim) o = lim;
      if (o < -lim) o = -lim;
      if (o > 32767) o = 32767;
      if (o < -32768) o = -32768;
      return eatrm_pkg::out_t'(o);
    end
  endfunction

  // reduce by the nearest multiple of pi/2, rotate, then fold the quadrant back
  task automatic sine_cosine(input eatrm_pkg::angle_t v, output longint c, output longint s);
    longint a, k, z, x, y, dx, dy;
    begin
      a = longint'(v) * (64'sd1 <<< (32 - eatrm_pkg::AngleFrac));
      if (a >= 0) k = (a + quarter_turn_q32 / 2) / quarter_turn_q32;
      else k = -((-a + quarter_turn_q32 / 2) / quarter_turn_q32);
      z = a - k * quarter_turn_q32;
      x = 652032874;
      y = 0;
      for (int i = 0; i < eatrm_pkg::Steps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= arctan_q32[i];
        end else begin
          x += dx; y -= dy; z += arctan_q32[i];
        end
      end
      case (k[1:0])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    end
  endtask

  task automatic predict_matrix(input eatrm_pkg::angle_t r, input eatrm_pkg::angle_t p,
                                input eatrm_pkg::angle_t w, output matrix_t m);
    longint rc, rs, pc, ps, yc, ys;
    begin
      sine_cosine(r, rc, rs);
      sine_cosine(p, pc, ps);
      sine_cosine(w, yc, ys);
      m[0] = to_q14(round_mul(pc, yc));
      m[1] = to_q14(round_mul(round_mul(yc, ps), rs) - round_mul(rc, ys));
      m[2] = to_q14(round_mul(round_mul(rc, yc), ps) + round_mul(rs, ys));
      m[3] = to_q14(round_mul(pc, ys));
      m[4] = to_q14(round_mul(rc, yc) + round_mul(round_mul(ps, rs), ys));
      m[5] = to_q14(round_mul(round_mul(rc, ps), ys) - round_mul(yc, rs));
      m[6] = to_q14(-ps);
      m[7] = to_q14(round_mul(pc, rs));
      m[8] = to_q14(round_mul(pc, rc));
    end
  endtask

  initial begin
    longint q;
    q = arctan_inverse_q60(2) + arctan_inverse_q60(3);
    arctan_q32[0] = round_drop(q, 28);
    for (int i = 1; i < eatrm_pkg::Steps; i++)
      arctan_q32[i] = round_drop(arctan_inverse_q60(64'd1 << i), 28);
    quarter_turn_q32 = round_drop(2 * q, 28);
    mismatch_count = 0;
    wr_count = 0;
    rd_count = 0;
  end

  assign matrices_pending = wr_count - rd_count;

  always @(posedge clk) begin
    matrix_t m, got;
    if (rst_n && in_valid && in_ready) begin
      predict_matrix(in_roll_angle, in_pitch_angle, in_yaw_angle, m);
      expected_ring[wr_count % RingDepth] = m;
      wr_count = wr_count + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      got = '{out_row0_col0, out_row0_col1, out_row0_col2,
              out_row1_col0, out_row1_col1, out_row1_col2,
              out_row2_col0, out_row2_col1, out_row2_col2};
      if (wr_count == rd_count) begin
        $display("%0t: unexpected output transaction", $realtime);
        mismatch_count = mismatch_count + 1;
      end else begin
        m = expected_ring[rd_count % RingDepth];
        rd_count = rd_count + 1;
        for (int i = 0; i < 9; i++)
          if (got[i] !== m[i]) begin
            $display("%0t: entry %0d expected %0d actual %0d",
                     $realtime, i, m[i], got[i]);
            mismatch_count = mismatch_count + 1;
          end
      end
    end
  end
endmodule

// ----- bench/euler_angles_to_rotation_matrix_unit_tb.sv -----
module euler_angles_to_rotation_matrix_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomTransactions = 1400;
  localparam int QuietTail = 200;       // final transactions sent with no idling
  localparam int HoldOffCycles = 300;   // long receiver stall to fill the pipeline
  localparam int StallLimit = 4000;     // cycles with no transaction before giving up
  localparam int DrainCycles = 60;      // idle time after the last expected matrix is checked

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  eatrm_pkg::angle_t in_roll_angle = '0, in_pitch_angle = '0, in_yaw_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  eatrm_pkg::out_t out_row0_col0, out_row0_col1, out_row0_col2;
  eatrm_pkg::out_t out_row1_col0, out_row1_col1, out_row1_col2;
  eatrm_pkg::out_t out_row2_col0, out_row2_col1, out_row2_col2;
  int mismatch_count, matrices_pending;
  bit quiet_phase = 1'b0;
  int idle_run = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  euler_angles_to_rotation_matrix_unit DUT (.*);
  rotation_matrix_checker checker_i (.*);

  // Offer one angle triple and hold it until the handshake completes.
  task automatic offer_angles(input eatrm_pkg::angle_t r, input eatrm_pkg::angle_t p,
                              input eatrm_pkg::angle_t w);
    int gap;
    begin
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        // idle burst on the sender side
        in_valid <= 1'b0;
        gap = $urandom_range(1, 7);
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_roll_angle <= r;
      in_pitch_angle <= p;
      in_yaw_angle <= w;
      do @(posedge clk); while (!in_ready);
    end
  endtask

  // Mostly legal angles in -pi..pi; now and then any 16-bit pattern.
  function automatic eatrm_pkg::angle_t random_angle();
    if ($urandom_range(0, 7) == 0) return eatrm_pkg::angle_t'($urandom_range(0, 16'hffff));
    return eatrm_pkg::angle_t'(int'($urandom_range(0, 51472)) - 25736);
  endfunction

  // Sender: directed corners first, then random triples.
  initial begin
    eatrm_pkg::angle_t corners [12] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
                                        -16'sd12868, 16'sd6434, -16'sd6434, 16'sd1,
                                        -16'sd1, 16'sd32767, 16'sh8000, 16'sd19302};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // sweep roll alone through the corners, then pitch with yaw, then all three
    for (int i = 0; i < 12; i++) offer_angles(corners[i], 16'sd0, 16'sd0);
    for (int i = 0; i < 6; i++) offer_angles(16'sd0, corners[i], corners[11 - i]);
    for (int i = 0; i < 6; i++) offer_angles(corners[i], corners[i], corners[i]);
    for (int n = 0; n < RandomTransactions; n++) begin
      if (n == RandomTransactions - QuietTail) quiet_phase = 1'b1;
      offer_angles(random_angle(), random_angle(), random_angle());
    end
    in_valid <= 1'b0;
    // drain: wait for every expectation, then let the pipeline settle
    while (matrices_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && matrices_pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Receiver: one long hold-off to back up the pipeline, then random stalls.
  initial begin
    int gap;
    repeat (11) @(posedge clk);
    out_ready <= 1'b0;
    repeat (HoldOffCycles) @(posedge clk);
    forever begin
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 7);
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      gap = $urandom_range(1, 20);
      repeat (gap) @(posedge clk);
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run <= 0;
      else idle_run <= idle_run + 1;
      if (idle_run >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end
endmodule

// ----- euler_angles_to_rotation_matrix_unit.f -----
design/eatrm_pkg.sv
design/eatrm_cell.sv
design/eatrm_sincos.sv
design/euler_angles_to_rotation_matrix_unit.sv
bench/rotation_matrix_checker.sv
bench/euler_angles_to_rotation_matrix_unit_tb.sv
